FILE: rtl/tqwa_pkg.sv
package tqwa_pkg;

  localparam int TAG_W    = 32;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 3;
  localparam int CREDIT_W = 4;

  // Credit and burst limit both come out of reset at this value.
  localparam logic [CREDIT_W-1:0] BASE_CREDIT = 4'd3;

  // Action codes. Bit one set means a service request, so code three serves as well.
  localparam logic [ACTION_W-1:0] ACT_ENQ_NORMAL   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ENQ_PRIORITY = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SERVE        = 2'd2;
  localparam int                  ACT_SERVE_BIT    = 1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_ENQUEUED        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED         = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SERVED_PRIORITY = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SERVED_NORMAL   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_WAIT            = 3'd4;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [TAG_W-1:0]    item_tag;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    served_tag;
  } out_item_t;

endpackage

FILE: rtl/two_queue_weighted_arbiter.sv
// Two-queue weighted arbiter.
//
// The input channel (in_valid, in_stall, in_data) carries one transaction per
// request: enqueue a tag on the normal queue, enqueue a tag on the priority
// queue, or ask for one service. Every input transaction produces exactly one
// result transaction on the output channel (out_valid, out_stall, out_data)
// carrying a status code and, for a service, the tag taken from a queue.
// The cfg_we / cfg_wdata port writes the burst limit, the number of priority
// services allowed before a normal service is forced; write it only while the
// block is idle.
//
// An accepted request sits in the input register while the decision logic
// updates queue heads, counts and the credit and reads the queue memory, and
// the result register captures the outcome together with the read data once it
// is free. Throughput is one per cycle while the receiver does not stall.
//
// Reset empties both queues and sets the credit and burst limit to three; the
// queue memories themselves are not cleared. When the receiver stalls, the
// result holds and the pipeline freezes behind it; in_stall rises only once
// the input register is also occupied.
module two_queue_weighted_arbiter #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  tqwa_pkg::in_item_t                in_data,

  output logic                              out_valid,
  input  logic                              out_stall,
  output tqwa_pkg::out_item_t               out_data,

  input  logic                              cfg_we,
  input  logic [tqwa_pkg::CREDIT_W-1:0]     cfg_wdata
);

  localparam int HW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;

  localparam logic [HW-1:0] HEAD_LAST = HW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(QUEUE_DEPTH);
  localparam logic [SW-1:0] SUM_DEPTH = SW'(QUEUE_DEPTH);

  // Input register.
  logic                 in_valid_r;
  tqwa_pkg::in_item_t   in_r;

  // Queue control state.
  logic [HW-1:0]        nhead_r, nhead_nxt;
  logic [CW-1:0]        ncount_r, ncount_nxt;
  logic [HW-1:0]        phead_r, phead_nxt;
  logic [CW-1:0]        pcount_r, pcount_nxt;
  logic [tqwa_pkg::CREDIT_W-1:0] credit_r, credit_nxt;
  logic [tqwa_pkg::CREDIT_W-1:0] burst_r;

  // Result register.
  logic                 out_valid_r;
  logic [tqwa_pkg::STATUS_W-1:0] out_status_r;
  logic                 out_has_tag_r;
  logic                 out_sel_pri_r;

  logic [tqwa_pkg::STATUS_W-1:0] status_nxt;
  logic                 advance;
  logic                 is_serve;
  logic                 to_pri;
  logic                 n_push, p_push, n_pop, p_pop;
  logic [SW-1:0]        ntail_sum, ptail_sum;
  logic [HW-1:0]        ntail, ptail;
  logic [tqwa_pkg::TAG_W-1:0] nrd, prd;

  // The decision stage moves forward whenever the result register is free
  // or is being emptied this cycle.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;

  assign is_serve = in_r.action[tqwa_pkg::ACT_SERVE_BIT];
  assign to_pri   = (in_r.action == tqwa_pkg::ACT_ENQ_PRIORITY);

  // Tail address is head plus occupancy, wrapped at the queue depth. The sum
  // stays below twice the depth, so one compare and subtract suffices.
  assign ntail_sum = SW'(nhead_r) + SW'(ncount_r);
  assign ptail_sum = SW'(phead_r) + SW'(pcount_r);
  assign ntail = (ntail_sum >= SUM_DEPTH) ? HW'(ntail_sum - SUM_DEPTH) : HW'(ntail_sum);
  assign ptail = (ptail_sum >= SUM_DEPTH) ? HW'(ptail_sum - SUM_DEPTH) : HW'(ptail_sum);

  always_comb begin
    status_nxt = tqwa_pkg::ST_WAIT;
    n_push     = 1'b0;
    p_push     = 1'b0;
    n_pop      = 1'b0;
    p_pop      = 1'b0;
    credit_nxt = credit_r;
    if (!is_serve) begin
      if (to_pri) begin
        p_push     = (pcount_r != COUNT_FULL);
        status_nxt = p_push ? tqwa_pkg::ST_ENQUEUED : tqwa_pkg::ST_DROPPED;
      end else begin
        n_push     = (ncount_r != COUNT_FULL);
        status_nxt = n_push ? tqwa_pkg::ST_ENQUEUED : tqwa_pkg::ST_DROPPED;
      end
    end else if ((pcount_r != '0) && ((credit_r != '0) || (ncount_r == '0))) begin
      // Priority service; the credit saturates at zero.
      p_pop      = 1'b1;
      status_nxt = tqwa_pkg::ST_SERVED_PRIORITY;
      if (credit_r != '0) begin
        credit_nxt = credit_r - 1'b1;
      end
    end else if (ncount_r != '0) begin
      n_pop      = 1'b1;
      status_nxt = tqwa_pkg::ST_SERVED_NORMAL;
      credit_nxt = burst_r;
    end
  end

  always_comb begin
    nhead_nxt  = nhead_r;
    ncount_nxt = ncount_r;
    phead_nxt  = phead_r;
    pcount_nxt = pcount_r;
    if (n_push) begin
      ncount_nxt = ncount_r + 1'b1;
    end
    if (n_pop) begin
      ncount_nxt = ncount_r - 1'b1;
      nhead_nxt  = (nhead_r == HEAD_LAST) ? '0 : nhead_r + 1'b1;
    end
    if (p_push) begin
      pcount_nxt = pcount_r + 1'b1;
    end
    if (p_pop) begin
      pcount_nxt = pcount_r - 1'b1;
      phead_nxt  = (phead_r == HEAD_LAST) ? '0 : phead_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      nhead_r       <= '0;
      ncount_r      <= '0;
      phead_r       <= '0;
      pcount_r      <= '0;
      credit_r      <= tqwa_pkg::BASE_CREDIT;
      burst_r       <= tqwa_pkg::BASE_CREDIT;
    end else begin
      if (cfg_we) begin
        burst_r <= cfg_wdata;
      end
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
        if (in_valid_r) begin
          nhead_r  <= nhead_nxt;
          ncount_r <= ncount_nxt;
          phead_r  <= phead_nxt;
          pcount_r <= pcount_nxt;
          credit_r <= credit_nxt;
        end
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_status_r  <= status_nxt;
      out_has_tag_r <= n_pop || p_pop;
      out_sel_pri_r <= p_pop;
    end
  end

  // Queue memories. A pop reads the head entry; the registered read data
  // lines up with the result register and holds while the result stalls.
  tqwa_ram #(
    .WIDTH (tqwa_pkg::TAG_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_normal_ram (
    .clk   (clk),
    .we    (advance && in_valid_r && n_push),
    .waddr (ntail),
    .wdata (in_r.item_tag),
    .re    (advance && in_valid_r && n_pop),
    .raddr (nhead_r),
    .rdata (nrd)
  );

  tqwa_ram #(
    .WIDTH (tqwa_pkg::TAG_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_priority_ram (
    .clk   (clk),
    .we    (advance && in_valid_r && p_push),
    .waddr (ptail),
    .wdata (in_r.item_tag),
    .re    (advance && in_valid_r && p_pop),
    .raddr (phead_r),
    .rdata (prd)
  );

  assign out_valid           = out_valid_r;
  assign out_data.status     = out_status_r;
  assign out_data.served_tag = !out_has_tag_r ? '0 : (out_sel_pri_r ? prd : nrd);

  // Occupancy never exceeds the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ncount_r <= COUNT_FULL) && (pcount_r <= COUNT_FULL))
    else $error("queue occupancy above depth");

  // A priority service removes exactly one entry from the priority queue.
  a_pri_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_valid_r && (status_nxt == tqwa_pkg::ST_SERVED_PRIORITY))
    |=> (pcount_r == $past(pcount_r) - 1'b1))
    else $error("priority service did not pop the priority queue");

  // The input side only holds off while the decision stage is occupied.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

  // A result carries a tag only for the two service codes.
  a_tag_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_has_tag_r) |->
      ((out_status_r == tqwa_pkg::ST_SERVED_PRIORITY) ||
       (out_status_r == tqwa_pkg::ST_SERVED_NORMAL)))
    else $error("served tag attached to a non-service result");

endmodule

FILE: rtl/tqwa_ram.sv
module tqwa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
